// File: hdl/atpf_pkg.sv
// Shared types and constants for the affine tilemap pixel fetch block.
package atpf_pkg;

  // Field and storage widths
  localparam int OP_W       = 3;
  localparam int VADDR_W    = 16;
  localparam int WDATA_W    = 16;
  localparam int COLOR_W    = 16;
  localparam int PAL_IDX_W  = 8;
  localparam int REF_W      = 28;
  localparam int STEP_W     = 16;
  localparam int COORD_W    = 32;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int FRAC_W     = 8;

  // Fixed memory sizes
  localparam int VIDEO_BYTES     = 65536;
  localparam int PALETTE_ENTRIES = 256;

  // Request operation codes; the two unused codes are ignored
  typedef enum logic [OP_W-1:0] {
    OP_VIDEO_WR   = 3'd0,
    OP_PAL_WR     = 3'd1,
    OP_RELOAD     = 3'd2,
    OP_LINE_START = 3'd3,
    OP_PIXEL      = 3'd4,
    OP_LINE_END   = 3'd5
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_X      = 3'd0,
    CFG_REF_Y      = 3'd1,
    CFG_DX_PIX     = 3'd2,
    CFG_DX_LINE    = 3'd3,
    CFG_DY_PIX     = 3'd4,
    CFG_DY_LINE    = 3'd5,
    CFG_MAP_LAYOUT = 3'd6
  } cfg_idx_t;

  // Map layout register fields
  typedef struct packed {
    logic [1:0] chr_base;
    logic [4:0] map_base;
    logic       wrap;
    logic [1:0] size;
  } layout_t;

  // One finished pixel result
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [COLOR_W-1:0] color;
    logic               visible;
  } pix_res_t;

endpackage

// File: hdl/atpf_if.sv
// Handshake channel interfaces for requests, results and configuration writes.
interface atpf_in_if import atpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [VADDR_W-1:0] write_address;
  logic [WDATA_W-1:0] write_data;

  modport source(output valid, operation, write_address, write_data, input ready);
  modport sink(input valid, operation, write_address, write_data, output ready);
endinterface

interface atpf_out_if import atpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [COLOR_W-1:0] color;
  logic               visible;

  modport source(output valid, column, color, visible, input ready);
  modport sink(input valid, column, color, visible, output ready);
endinterface

interface atpf_cfg_if import atpf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/affine_tilemap_pixel_fetch_top.sv
// Rotation and scaling background pixel fetch: coordinates, video memory and palette.
//
// Channels: in_ch carries requests (video write, palette write, reference reload,
// line start, pixel, line end); out_ch carries one result per pixel request whose
// column lies inside the screen width; cfg_ch writes the reference point, the four
// 8.8 steps and the map layout. cfg_ch is always ready.
// Throughput: one request per cycle while in_ch is ready. A pixel result is offered
// on out_ch once the request has passed its registered steps: the map byte is read at
// the accepting edge, then the character byte (the two read ports of video memory),
// then the palette entry, and then the result is written into the result queue.
// Video writes land at acceptance; palette writes pass the registers pw1 and pw2 and land
// in step with the palette read of the pixels around them, so request order is kept.
// Stalls: results wait in an 8-entry queue; in_ch stays ready while fewer than
// eight results are queued or in flight, so requests keep flowing while a result
// waits, and nothing is dropped when out_ch.ready stays low.
// Reset (rst_n low, synchronous): configuration takes its reset values, line
// origin, running coordinates and column clear, the queue empties. Video memory
// and palette are not cleared and must be written before they are read.
module affine_tilemap_pixel_fetch_top import atpf_pkg::*; #(
  parameter int SCREEN_WIDTH = 240
) (
  input logic        clk,
  input logic        rst_n,
  atpf_cfg_if.sink   cfg_ch,
  atpf_in_if.sink    in_ch,
  atpf_out_if.source out_ch
);

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam logic [COL_W-1:0] SCREEN_W_C = COL_W'(SCREEN_WIDTH);
  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(FIFO_DEPTH);

  // Configuration registers
  logic [REF_W-1:0]  ref_x_r, ref_y_r;
  logic [STEP_W-1:0] dx_pix_r, dx_line_r, dy_pix_r, dy_line_r;
  layout_t           layout_r;
  logic              cfg_fire;

  // Coordinate state
  logic [COORD_W-1:0] org_x_r, org_y_r, run_x_r, run_y_r;
  logic [COL_W-1:0]   col_r;

  // Request decode
  logic in_fire, col_ok, pix_go, vid_wr, pal_wr;

  // Stage 0 address math
  logic [23:0]        tx_int, ty_int;
  logic [3:0]         sz_log;
  logic [9:0]         coord_mask, txm, tym;
  logic               in_map;
  logic [13:0]        row_off;
  logic [VADDR_W-1:0] map_addr, chr_addr;

  // Memories and their read registers
  logic [7:0]         vmem [VIDEO_BYTES];
  logic [COLOR_W-1:0] pmem [PALETTE_ENTRIES];
  logic [7:0]         rd_map_r, rd_chr_r;
  logic [COLOR_W-1:0] rd_pal_r;

  // Pixel pipeline
  logic             s1_vld_r, s2_vld_r, s3_vld_r;
  logic             s1_in_r, s2_in_r, s3_vis_r;
  logic [5:0]       s1_fine_r;
  logic [COL_W-1:0] s1_col_r, s2_col_r, s3_col_r;

  // Delayed palette write
  logic                 pw1_vld_r, pw2_vld_r;
  logic [PAL_IDX_W-1:0] pw1_idx_r, pw2_idx_r;
  logic [COLOR_W-1:0]   pw1_dat_r, pw2_dat_r;

  // Result queue and credits
  pix_res_t         fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r, credit_r;
  logic             out_fire;
  pix_res_t         push_item;

  // Configuration write port
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r   <= '0;
      ref_y_r   <= '0;
      dx_pix_r  <= STEP_W'(256);
      dx_line_r <= '0;
      dy_pix_r  <= '0;
      dy_line_r <= STEP_W'(256);
      layout_r  <= '0;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        CFG_REF_X:      ref_x_r   <= cfg_ch.data;
        CFG_REF_Y:      ref_y_r   <= cfg_ch.data;
        CFG_DX_PIX:     dx_pix_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_DX_LINE:    dx_line_r <= cfg_ch.data[STEP_W-1:0];
        CFG_DY_PIX:     dy_pix_r  <= cfg_ch.data[STEP_W-1:0];
        CFG_DY_LINE:    dy_line_r <= cfg_ch.data[STEP_W-1:0];
        CFG_MAP_LAYOUT: layout_r  <= layout_t'(cfg_ch.data[$bits(layout_t)-1:0]);
        default: ;
      endcase
    end
  end

  // Decode the accepted request
  assign in_ch.ready = credit_r < DEPTH_C;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign col_ok      = col_r < SCREEN_W_C;
  assign pix_go      = in_fire && (in_ch.operation == OP_PIXEL) && col_ok;
  assign vid_wr      = in_fire && (in_ch.operation == OP_VIDEO_WR);
  assign pal_wr      = in_fire && (in_ch.operation == OP_PAL_WR);

  // Advance line origin, running coordinates and column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      run_x_r <= '0;
      run_y_r <= '0;
      col_r   <= '0;
    end else if (in_fire) begin
      case (in_ch.operation)
        OP_RELOAD: begin
          org_x_r <= {{(COORD_W-REF_W){ref_x_r[REF_W-1]}}, ref_x_r};
          org_y_r <= {{(COORD_W-REF_W){ref_y_r[REF_W-1]}}, ref_y_r};
        end
        OP_LINE_START: begin
          run_x_r <= org_x_r;
          run_y_r <= org_y_r;
          col_r   <= '0;
        end
        OP_LINE_END: begin
          org_x_r <= org_x_r + {{(COORD_W-STEP_W){dx_line_r[STEP_W-1]}}, dx_line_r};
          org_y_r <= org_y_r + {{(COORD_W-STEP_W){dy_line_r[STEP_W-1]}}, dy_line_r};
        end
        OP_PIXEL: begin
          if (col_ok) begin
            col_r   <= col_r + COL_W'(1);
            run_x_r <= run_x_r + {{(COORD_W-STEP_W){dx_pix_r[STEP_W-1]}}, dx_pix_r};
            run_y_r <= run_y_r + {{(COORD_W-STEP_W){dy_pix_r[STEP_W-1]}}, dy_pix_r};
          end
        end
        default: ;
      endcase
    end
  end

  // Wrap or clip the integer coordinates and form the map byte address
  always_comb begin
    tx_int     = run_x_r[COORD_W-1:FRAC_W];
    ty_int     = run_y_r[COORD_W-1:FRAC_W];
    sz_log     = 4'd7 + {2'b00, layout_r.size};
    coord_mask = 10'((11'd128 << layout_r.size) - 11'd1);
    txm        = tx_int[9:0] & coord_mask;
    tym        = ty_int[9:0] & coord_mask;
    // a negative coordinate has its high bits set, so it clips too
    in_map     = layout_r.wrap ||
                 (((tx_int >> sz_log) == '0) && ((ty_int >> sz_log) == '0));
    row_off    = 14'(tym[9:3]) << (3'd4 + {1'b0, layout_r.size});
    map_addr   = {layout_r.map_base, 11'd0} + {2'b00, row_off} + {9'd0, txm[9:3]};
    chr_addr   = {layout_r.chr_base, 14'd0} + {2'b00, rd_map_r, s1_fine_r};
  end

  // Video memory: one write port, map and character read ports
  always_ff @(posedge clk) begin
    if (vid_wr) begin
      vmem[in_ch.write_address] <= in_ch.write_data[7:0];
    end
    rd_map_r <= vmem[map_addr];
    rd_chr_r <= vmem[chr_addr];
  end

  // Palette memory: write from the delayed palette request, read by character byte
  always_ff @(posedge clk) begin
    if (pw2_vld_r) begin
      pmem[pw2_idx_r] <= pw2_dat_r;
    end
    rd_pal_r <= pmem[rd_chr_r];
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      pw1_vld_r <= 1'b0;
      pw2_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= pix_go;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      pw1_vld_r <= pal_wr;
      pw2_vld_r <= pw1_vld_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_in_r   <= in_map;
    s1_fine_r <= {tym[2:0], txm[2:0]};
    s1_col_r  <= col_r;
    s2_in_r   <= s1_in_r;
    s2_col_r  <= s1_col_r;
    s3_vis_r  <= s2_in_r && (rd_chr_r != 8'd0);
    s3_col_r  <= s2_col_r;
    pw1_idx_r <= in_ch.write_address[PAL_IDX_W-1:0];
    pw1_dat_r <= in_ch.write_data;
    pw2_idx_r <= pw1_idx_r;
    pw2_dat_r <= pw1_dat_r;
  end

  // Result queue
  assign push_item.column  = s3_col_r;
  assign push_item.color   = s3_vis_r ? rd_pal_r : '0;
  assign push_item.visible = s3_vis_r;

  assign out_ch.valid   = fifo_cnt_r != '0;
  assign out_ch.column  = fifo_q[rd_ptr_r].column;
  assign out_ch.color   = fifo_q[rd_ptr_r].color;
  assign out_ch.visible = fifo_q[rd_ptr_r].visible;
  assign out_fire       = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      fifo_q[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      credit_r   <= '0;
    end else begin
      if (s3_vld_r) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(s3_vld_r) - CNT_W'(out_fire);
      credit_r   <= credit_r + CNT_W'(pix_go) - CNT_W'(out_fire);
    end
  end

  // Checks
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= DEPTH_C) else $error("result credit count above queue depth");

  a_queue_le_credit: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= credit_r) else $error("queue holds more results than reserved");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> fifo_cnt_r < DEPTH_C) else $error("result pushed into full queue");

  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pix_go |=> s1_vld_r) else $error("accepted pixel did not enter the pipeline");

  a_pop_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> credit_r != '0) else $error("result delivered without a reservation");

endmodule

// File: tb/atpf_pixel_checker.sv
// Checker for the affine tilemap pixel fetch: predicts every pixel result and compares it.
`timescale 1ns / 1ps

module atpf_pixel_checker import atpf_pkg::*; #(
  parameter int SCREEN_WIDTH = 240
) (
  input  logic clk,
  input  logic rst_n,
  atpf_cfg_if  cfg_ch,
  atpf_in_if   in_ch,
  atpf_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  // Register copies
  logic [REF_W-1:0]  ref_x, ref_y;
  logic [STEP_W-1:0] dx_pix, dx_line, dy_pix, dy_line;
  layout_t           layout;

  // Walk state and memories
  logic [COORD_W-1:0] org_x, org_y, run_x, run_y;
  int unsigned        col;
  logic [7:0]         vram [VIDEO_BYTES];
  logic [COLOR_W-1:0] palette [PALETTE_ENTRIES];

  // Pixels still owed by the block, oldest first
  pix_res_t due_pixels[$];

  function automatic logic [COORD_W-1:0] widen_step(input logic [STEP_W-1:0] s);
    return {{(COORD_W-STEP_W){s[STEP_W-1]}}, s};
  endfunction

  // Fetch one pixel at the running coordinates, then advance along the line
  function automatic pix_res_t render_pixel();
    logic [COORD_W-1:0] span, tx, ty, map_addr, chr_addr;
    logic [7:0]         tile, pidx;
    pix_res_t           res;
    span = 32'd128 << layout.size;
    tx = $signed(run_x) >>> FRAC_W;
    ty = $signed(run_y) >>> FRAC_W;
    res.column  = col[COL_W-1:0];
    res.color   = '0;
    res.visible = 1'b0;
    // wrap masks to the map; otherwise negative values look huge and clip
    if (layout.wrap) begin
      tx &= span - 1;
      ty &= span - 1;
    end
    if (tx < span && ty < span) begin
      map_addr = 32'(layout.map_base) * 32'h800 + (ty >> 3) * (span >> 3) + (tx >> 3);
      tile = vram[map_addr[15:0]];
      chr_addr = 32'(layout.chr_base) * 32'h4000 + 32'(tile) * 64 + (ty & 7) * 8 + (tx & 7);
      pidx = vram[chr_addr[15:0]];
      if (pidx != 8'd0) begin
        res.color   = palette[pidx];
        res.visible = 1'b1;
      end
    end
    col++;
    run_x += widen_step(dx_pix);
    run_y += widen_step(dy_pix);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    pix_res_t want;
    if (!rst_n) begin
      ref_x      = '0;
      ref_y      = '0;
      dx_pix     = 16'h0100;
      dx_line    = '0;
      dy_pix     = '0;
      dy_line    = 16'h0100;
      layout     = '0;
      org_x      = '0;
      org_y      = '0;
      run_x      = '0;
      run_y      = '0;
      col        = 0;
      fail_count = 0;
      due_pixels.delete();
    end else begin
      // Track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_REF_X:      ref_x   = cfg_ch.data[REF_W-1:0];
          CFG_REF_Y:      ref_y   = cfg_ch.data[REF_W-1:0];
          CFG_DX_PIX:     dx_pix  = cfg_ch.data[STEP_W-1:0];
          CFG_DX_LINE:    dx_line = cfg_ch.data[STEP_W-1:0];
          CFG_DY_PIX:     dy_pix  = cfg_ch.data[STEP_W-1:0];
          CFG_DY_LINE:    dy_line = cfg_ch.data[STEP_W-1:0];
          CFG_MAP_LAYOUT: layout  = layout_t'(cfg_ch.data[9:0]);
          default: ;
        endcase
      end

      // Apply each accepted request in order
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          OP_VIDEO_WR: vram[in_ch.write_address] = in_ch.write_data[7:0];
          OP_PAL_WR:   palette[in_ch.write_address[PAL_IDX_W-1:0]] = in_ch.write_data;
          OP_RELOAD: begin
            org_x = {{(COORD_W-REF_W){ref_x[REF_W-1]}}, ref_x};
            org_y = {{(COORD_W-REF_W){ref_y[REF_W-1]}}, ref_y};
          end
          OP_LINE_START: begin
            run_x = org_x;
            run_y = org_y;
            col   = 0;
          end
          OP_PIXEL: begin
            // past the screen width nothing moves and nothing comes out
            if (col < SCREEN_WIDTH) due_pixels.push_back(render_pixel());
          end
          OP_LINE_END: begin
            org_x += widen_step(dx_line);
            org_y += widen_step(dy_line);
          end
          default: ;
        endcase
      end

      // Compare each result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (due_pixels.size() == 0) begin
          $error("unexpected result: column %0d color %h visible %0d",
                 out_ch.column, out_ch.color, out_ch.visible);
          fail_count++;
        end else begin
          want = due_pixels.pop_front();
          if (out_ch.column !== want.column) begin
            $error("column mismatch: expected %0d, got %0d", want.column, out_ch.column);
            fail_count++;
          end
          if (out_ch.color !== want.color) begin
            $error("color mismatch: expected %h, got %h", want.color, out_ch.color);
            fail_count++;
          end
          if (out_ch.visible !== want.visible) begin
            $error("visible mismatch: expected %0d, got %0d", want.visible, out_ch.visible);
            fail_count++;
          end
        end
      end
    end
    pending <= due_pixels.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the pixel fetch testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_top import atpf_pkg::*; ();

  localparam int SCREEN_WIDTH  = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 125;

  // The two operation codes the block ignores
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   random_items;
  bit   send_calm;
  bit   drain_calm;

  // Stimulus copy of registers, coordinates and written entries, used to write
  // each byte and palette entry a pixel reads just before that pixel
  logic [REF_W-1:0]   sh_rx, sh_ry;
  logic [STEP_W-1:0]  sh_dxp, sh_dxl, sh_dyp, sh_dyl;
  layout_t            sh_lay;
  logic [COORD_W-1:0] sh_org_x, sh_org_y, sh_run_x, sh_run_y;
  int unsigned        sh_col;
  logic [7:0]         sh_vram [VIDEO_BYTES];
  bit                 vid_set [VIDEO_BYTES];
  bit                 pal_set [PALETTE_ENTRIES];

  atpf_cfg_if cfg_ch ();
  atpf_in_if  in_ch ();
  atpf_out_if out_ch ();

  affine_tilemap_pixel_fetch_top #(.SCREEN_WIDTH(SCREEN_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  atpf_pixel_checker #(.SCREEN_WIDTH(SCREEN_WIDTH)) pix_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall a random number of cycles after each taken result
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      gap = drain_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [COORD_W-1:0] widen_step(input logic [STEP_W-1:0] s);
    return {{(COORD_W-STEP_W){s[STEP_W-1]}}, s};
  endfunction

  // Follow each taken request in the stimulus copy
  function automatic void track_req(input logic [OP_W-1:0] op,
                                    input logic [VADDR_W-1:0] addr,
                                    input logic [WDATA_W-1:0] data);
    case (op)
      OP_VIDEO_WR: begin
        sh_vram[addr] = data[7:0];
        vid_set[addr] = 1'b1;
      end
      OP_PAL_WR: pal_set[addr[PAL_IDX_W-1:0]] = 1'b1;
      OP_RELOAD: begin
        sh_org_x = {{(COORD_W-REF_W){sh_rx[REF_W-1]}}, sh_rx};
        sh_org_y = {{(COORD_W-REF_W){sh_ry[REF_W-1]}}, sh_ry};
      end
      OP_LINE_START: begin
        sh_run_x = sh_org_x;
        sh_run_y = sh_org_y;
        sh_col   = 0;
      end
      OP_PIXEL: begin
        if (sh_col < SCREEN_WIDTH) begin
          sh_col++;
          sh_run_x += widen_step(sh_dxp);
          sh_run_y += widen_step(sh_dyp);
        end
      end
      OP_LINE_END: begin
        sh_org_x += widen_step(sh_dxl);
        sh_org_y += widen_step(sh_dyl);
      end
      default: ;
    endcase
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_req(input logic [OP_W-1:0] op, input logic [VADDR_W-1:0] addr,
                          input logic [WDATA_W-1:0] data);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.write_address <= addr;
    in_ch.write_data    <= data;
    do @(posedge clk); while (!in_ch.ready);
    track_req(op, addr, data);
    if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) random_items++;
  endtask

  // Write the map byte, character byte and palette entry of the next pixel where unwritten
  task automatic fill_for_pixel();
    logic [COORD_W-1:0] span, tx, ty, map_addr, chr_addr;
    logic [7:0]         pidx;
    span = 32'd128 << sh_lay.size;
    tx   = $signed(sh_run_x) >>> FRAC_W;
    ty   = $signed(sh_run_y) >>> FRAC_W;
    if (sh_lay.wrap) begin
      tx &= span - 1;
      ty &= span - 1;
    end
    if (sh_col < SCREEN_WIDTH && tx < span && ty < span) begin
      map_addr = 32'(sh_lay.map_base) * 32'h800 + (ty >> 3) * (span >> 3) + (tx >> 3);
      if (!vid_set[map_addr[15:0]]) send_req(OP_VIDEO_WR, map_addr[15:0], 16'($urandom));
      chr_addr = 32'(sh_lay.chr_base) * 32'h4000 + 32'(sh_vram[map_addr[15:0]]) * 64
                 + (ty & 7) * 8 + (tx & 7);
      // about a quarter of the character bytes are transparent
      if (!vid_set[chr_addr[15:0]]) begin
        send_req(OP_VIDEO_WR, chr_addr[15:0],
                 {8'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom)});
      end
      pidx = sh_vram[chr_addr[15:0]];
      if (pidx != 8'd0 && !pal_set[pidx]) begin
        send_req(OP_PAL_WR, {8'($urandom), pidx}, 16'($urandom));
      end
    end
  endtask

  task automatic send_rand(input logic [OP_W-1:0] op);
    if (op == OP_PIXEL) fill_for_pixel();
    send_req(op, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_rand(OP_VIDEO_WR);
      1: send_rand(OP_PAL_WR);
      2: send_rand(OP_RELOAD);
      3: send_rand(OP_UNUSED_LO);
      default: send_rand(OP_UNUSED_HI);
    endcase
  endtask

  // Drop valid, wait for every owed pixel, then let the pipeline drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Write all seven registers; unused high bits of the narrow ones carry noise
  task automatic program_regs(input logic [REF_W-1:0] rx, input logic [REF_W-1:0] ry,
                              input logic [STEP_W-1:0] dxp, input logic [STEP_W-1:0] dxl,
                              input logic [STEP_W-1:0] dyp, input logic [STEP_W-1:0] dyl,
                              input logic [9:0] lay);
    write_reg(CFG_REF_X, rx);
    write_reg(CFG_REF_Y, ry);
    write_reg(CFG_DX_PIX, {12'($urandom), dxp});
    write_reg(CFG_DX_LINE, {12'($urandom), dxl});
    write_reg(CFG_DY_PIX, {12'($urandom), dyp});
    write_reg(CFG_DY_LINE, {12'($urandom), dyl});
    write_reg(CFG_MAP_LAYOUT, {18'($urandom), lay});
    cfg_ch.valid <= 1'b0;
    sh_rx  = rx;
    sh_ry  = ry;
    sh_dxp = dxp;
    sh_dxl = dxl;
    sh_dyp = dyp;
    sh_dyl = dyl;
    sh_lay = layout_t'(lay);
  endtask

  // Mostly gentle steps, sometimes the full signed range
  function automatic logic [STEP_W-1:0] pick_step();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // Reference point a little around the map so both clip edges show up
  function automatic logic [REF_W-1:0] pick_ref(input logic [1:0] size_code);
    int unsigned span;
    span = 128 << size_code;
    return 28'(($urandom_range(0, span + 127) - 64) * 256 + $urandom_range(0, 255));
  endfunction

  task automatic load_phase(input int p);
    logic [9:0] lay;
    if (p == 0) begin
      program_regs(28'h8000000, 28'h8000000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 10'h000);
    end else if (p == 1) begin
      program_regs(28'h7FFFFFF, 28'h7FFFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'h3FF);
    end else begin
      lay = 10'($urandom);
      program_regs(pick_ref(lay[1:0]), pick_ref(lay[1:0]), pick_step(), pick_step(),
                   pick_step(), pick_step(), lay);
    end
  endtask

  // One scan line, now and then missing its start or end
  task automatic run_line(input bit long_line);
    int n;
    if ($urandom_range(0, 7) == 0) send_rand(OP_RELOAD);
    if (long_line || $urandom_range(0, 11) != 0) send_rand(OP_LINE_START);
    n = long_line ? SCREEN_WIDTH + 5 : $urandom_range(1, 24);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_rand(OP_PIXEL);
    end
    if ($urandom_range(0, 11) != 0) send_rand(OP_LINE_END);
  endtask

  initial begin
    bit first_line;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_VIDEO_WR;
    in_ch.write_address = '0;
    in_ch.write_data    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_REF_X;
    cfg_ch.data         = '0;
    send_calm           = 1'b1;
    drain_calm          = 1'b1;
    random_items        = 0;
    sh_rx               = '0;
    sh_ry               = '0;
    sh_dxp              = 16'h0100;
    sh_dxl              = '0;
    sh_dyp              = '0;
    sh_dyl              = 16'h0100;
    sh_lay              = '0;
    sh_org_x            = '0;
    sh_org_y            = '0;
    sh_run_x            = '0;
    sh_run_y            = '0;
    sh_col              = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ignored codes, top entries, a short walk at reset settings
    send_calm  = 1'b0;
    drain_calm = 1'b0;
    send_rand(OP_UNUSED_LO);
    send_rand(OP_UNUSED_HI);
    send_req(OP_PAL_WR, 16'hFFFF, 16'hFFFF);
    send_req(OP_VIDEO_WR, 16'hFFFF, 16'hFFFF);
    send_rand(OP_RELOAD);
    send_rand(OP_LINE_START);
    repeat (3) send_rand(OP_PIXEL);
    send_rand(OP_LINE_END);
    send_rand(OP_LINE_START);
    send_rand(OP_PIXEL);

    // Directed: start left of a large map near its bottom, clipped then wrapped,
    // with the map base high enough that map addresses roll over
    for (int w = 0; w < 2; w++) begin
      settle();
      program_regs(28'hFFFFD80, 28'(1000 * 256), 16'h0100, 16'h0000, 16'h0000, 16'h0100,
                   {2'b11, 5'h1F, 1'(w), 2'b11});
      send_rand(OP_RELOAD);
      send_rand(OP_LINE_START);
      repeat (4) send_rand(OP_PIXEL);
    end

    // Random phases, each under fresh register settings
    random_items = 0;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_phase(p);
      send_calm  = (p % 4 == 3);
      drain_calm = (p % 4 == 1);
      send_rand(OP_RELOAD);
      first_line = 1'b1;
      while (random_items < (p + 1) * PHASE_ITEMS) begin
        run_line(first_line && (p == 3 || p == 7));
        first_line = 1'b0;
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
